// ===== sv/mhe_pkg.sv =====
// mhe_pkg: shared types and constants of the msgpack header encoder
// operation codes, per-item byte job, queue status; no dependencies

package mhe_pkg;

   // operation codes of an input transaction
   typedef enum logic [3:0] {
      OP_NIL    = 4'd0,
      OP_FALSE  = 4'd1,
      OP_TRUE   = 4'd2,
      OP_SINT   = 4'd3,
      OP_UINT64 = 4'd4,
      OP_FLOAT  = 4'd5,
      OP_BIN    = 4'd6,
      OP_STR    = 4'd7,
      OP_ARRAY  = 4'd8,
      OP_MAP    = 4'd9,
      OP_EXT    = 4'd10,
      OP_TSTAMP = 4'd11,
      OP_RAW    = 4'd12
   } op_type;

   // longest encoding: ext 8 timestamp with 96-bit body
   localparam int JOB_BYTES   = 15;
   localparam int CNT_W       = $clog2(JOB_BYTES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] TS_EXT_TYPE_RESET = 8'hFF;

   // bytes of one transaction, data[0] goes out first
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;
      logic [CNT_W-1:0]          count;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

// ===== sv/mhe_front.sv =====
// mhe_front: classifies an accepted transaction into its encoded byte job
// holds the timestamp extension type register; uses mhe_pkg

module mhe_front import mhe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [3:0]       req_operation,
   input  logic [63:0]      req_value_bits,
   input  logic [31:0]      req_length,
   input  logic [31:0]      req_nanoseconds,
   input  logic [7:0]       req_ext_type,
   input  logic [7:0]       req_payload_byte,
   input  logic             csr_write,
   input  logic [7:0]       csr_timestamp_ext_type,
   output logic             push,
   output job_type          job
);

   logic [7:0]  ts_type_ff;
   logic [7:0]  ts_type_in;
   logic [63:0] ts_packed;
   job_type     job_c;

   // format byte followed by nb value bytes, most significant first
   function automatic job_type head_job(logic [7:0] code, logic [63:0] val, logic [3:0] nb);
      job_type j;
      j = '0;
      j.data[0] = code;
      j.count   = CNT_W'(nb + 4'd1);
      case (nb)
         4'd1: begin
            j.data[1] = val[7:0];
         end
         4'd2: begin
            for (int k = 0; k < 2; k++) j.data[1+k] = val[15-8*k -: 8];
         end
         4'd4: begin
            for (int k = 0; k < 4; k++) j.data[1+k] = val[31-8*k -: 8];
         end
         4'd8: begin
            for (int k = 0; k < 8; k++) j.data[1+k] = val[63-8*k -: 8];
         end
         default: begin
         end
      endcase
      return j;
   endfunction

   // header with 8-, 16- or 32-bit length
   function automatic job_type len3_job(logic [31:0] len, logic [7:0] c8,
                                        logic [7:0] c16, logic [7:0] c32);
      job_type j;
      if (len[31:8] == '0) begin
         j = head_job(c8, {32'd0, len}, 4'd1);
      end else if (len[31:16] == '0) begin
         j = head_job(c16, {32'd0, len}, 4'd2);
      end else begin
         j = head_job(c32, {32'd0, len}, 4'd4);
      end
      return j;
   endfunction

   // fix form below the limit, else 16- or 32-bit length
   function automatic job_type fix_job(logic [31:0] len, logic [7:0] fix, logic fix_ok,
                                       logic [7:0] c16, logic [7:0] c32);
      job_type j;
      if (fix_ok) begin
         j = head_job(fix | len[7:0], '0, 4'd0);
      end else if (len[31:16] == '0) begin
         j = head_job(c16, {32'd0, len}, 4'd2);
      end else begin
         j = head_job(c32, {32'd0, len}, 4'd4);
      end
      return j;
   endfunction

   // ext header plus the type byte
   function automatic job_type ext_job(logic [31:0] len, logic [7:0] typ);
      job_type j;
      case (len)
         32'd1:   j = head_job(8'hD4, '0, 4'd0);
         32'd2:   j = head_job(8'hD5, '0, 4'd0);
         32'd4:   j = head_job(8'hD6, '0, 4'd0);
         32'd8:   j = head_job(8'hD7, '0, 4'd0);
         32'd16:  j = head_job(8'hD8, '0, 4'd0);
         default: j = len3_job(len, 8'hC7, 8'hC8, 8'hC9);
      endcase
      j.data[j.count] = typ;
      j.count         = CNT_W'(j.count + 1'b1);
      return j;
   endfunction

   // timestamp type register; the user must write it only while idle, the block does not enforce it
   always_comb begin
      ts_type_in = ts_type_ff;
      if (csr_write) begin
         ts_type_in = csr_timestamp_ext_type;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_type_ff <= TS_EXT_TYPE_RESET;
      end else begin
         ts_type_ff <= ts_type_in;
      end
   end

   assign ts_packed = {req_nanoseconds[29:0], req_value_bits[33:0]};

   // classify the operation into its byte job
   always_comb begin
      job_c = '0;
      unique case (op_type'(req_operation))
         OP_NIL:    job_c = head_job(8'hC0, '0, 4'd0);
         OP_FALSE:  job_c = head_job(8'hC2, '0, 4'd0);
         OP_TRUE:   job_c = head_job(8'hC3, '0, 4'd0);
         OP_SINT: begin
            if (!req_value_bits[63]) begin
               if (req_value_bits[63:7] == '0) begin
                  job_c = head_job(req_value_bits[7:0], '0, 4'd0);
               end else if (req_value_bits[63:8] == '0) begin
                  job_c = head_job(8'hCC, req_value_bits, 4'd1);
               end else if (req_value_bits[63:16] == '0) begin
                  job_c = head_job(8'hCD, req_value_bits, 4'd2);
               end else if (req_value_bits[63:32] == '0) begin
                  job_c = head_job(8'hCE, req_value_bits, 4'd4);
               end else begin
                  job_c = head_job(8'hCF, req_value_bits, 4'd8);
               end
            end else begin
               if (&req_value_bits[63:5]) begin
                  job_c = head_job(req_value_bits[7:0], '0, 4'd0);
               end else if (&req_value_bits[63:7]) begin
                  job_c = head_job(8'hD0, req_value_bits, 4'd1);
               end else if (&req_value_bits[63:15]) begin
                  job_c = head_job(8'hD1, req_value_bits, 4'd2);
               end else if (&req_value_bits[63:31]) begin
                  job_c = head_job(8'hD2, req_value_bits, 4'd4);
               end else begin
                  job_c = head_job(8'hD3, req_value_bits, 4'd8);
               end
            end
         end
         OP_UINT64: job_c = head_job(8'hCF, req_value_bits, 4'd8);
         OP_FLOAT:  job_c = head_job(8'hCB, req_value_bits, 4'd8);
         OP_BIN:    job_c = len3_job(req_length, 8'hC4, 8'hC5, 8'hC6);
         OP_STR: begin
            if (req_length[31:5] == '0) begin
               job_c = head_job(8'hA0 | req_length[7:0], '0, 4'd0);
            end else begin
               job_c = len3_job(req_length, 8'hD9, 8'hDA, 8'hDB);
            end
         end
         OP_ARRAY:  job_c = fix_job(req_length, 8'h90, req_length[31:4] == '0,
                                    8'hDC, 8'hDD);
         OP_MAP:    job_c = fix_job(req_length, 8'h80, req_length[31:4] == '0,
                                    8'hDE, 8'hDF);
         OP_EXT:    job_c = ext_job(req_length, req_ext_type);
         OP_TSTAMP: begin
            if (req_value_bits[63:32] == '0 && req_nanoseconds == '0) begin
               // 32-bit seconds in fixext 4
               job_c.data[0] = 8'hD6;
               job_c.data[1] = ts_type_ff;
               for (int k = 0; k < 4; k++) job_c.data[2+k] = req_value_bits[31-8*k -: 8];
               job_c.count = CNT_W'(6);
            end else if (req_value_bits[63:34] == '0 && req_nanoseconds[31:30] == '0) begin
               // 30-bit ns with 34-bit seconds in fixext 8
               job_c.data[0] = 8'hD7;
               job_c.data[1] = ts_type_ff;
               for (int k = 0; k < 8; k++) job_c.data[2+k] = ts_packed[63-8*k -: 8];
               job_c.count = CNT_W'(10);
            end else begin
               // 96-bit form in ext 8 of length 12
               job_c.data[0] = 8'hC7;
               job_c.data[1] = 8'h0C;
               job_c.data[2] = ts_type_ff;
               for (int k = 0; k < 4; k++) job_c.data[3+k] = req_nanoseconds[31-8*k -: 8];
               for (int k = 0; k < 8; k++) job_c.data[7+k] = req_value_bits[63-8*k -: 8];
               job_c.count = CNT_W'(15);
            end
         end
         OP_RAW:    job_c = head_job(req_payload_byte, '0, 4'd0);
         default:   job_c = '0;
      endcase
   end

   // unused codes give an empty job and are dropped here
   assign job  = job_c;
   assign push = accept && (job_c.count != '0);

endmodule

// ===== sv/mhe_queue.sv =====
// mhe_queue: short job queue between the front and the byte emitter
// uses mhe_pkg for job_type and queue sizing

module mhe_queue import mhe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head             = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/mhe_back.sv =====
// mhe_back: walks the head job one byte per cycle into the result register
// uses mhe_pkg for job_type and queue status

module mhe_back import mhe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);

   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic             valid_ff;
   logic             valid_in;
   logic [7:0]       byte_ff;
   logic [7:0]       byte_in;
   logic             last_ff;
   logic             last_in;
   logic             at_end;

   assign at_end = (CNT_W'(idx_ff + 1'b1) == head.count);
   assign pop    = status.not_empty && at_end;

   // byte select and index step
   always_comb begin
      idx_in   = idx_ff;
      valid_in = status.not_empty;
      byte_in  = head.data[idx_ff];
      last_in  = at_end;
      if (status.not_empty) begin
         idx_in = at_end ? '0 : CNT_W'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== sv/msgpack_header_encoder_core.sv =====
// msgpack_header_encoder_core: top level of the MessagePack byte encoder
// instantiates mhe_front, mhe_queue and mhe_back; uses mhe_pkg
//
// Usage:
//   Input: drive req_* and raise start; the transaction is taken at a rising
//   edge with start high and busy low. Each transaction becomes 1 to 15
//   encoded bytes (header only for bin/str/array/map/ext; raw bytes pass
//   through as one byte). Codes 13 to 15 are taken and give no bytes.
//   Output: each byte appears for one cycle with rsp_valid high, rsp_last on
//   the final byte of a transaction. The receiver cannot stall the stream.
//   Config: csr_timestamp_ext_type is written when csr_valid and csr_ready
//   are high; csr_ready is always high. Write only while idle.
// Timing:
//   With the queue empty, an accepted job is written into the job queue and
//   its first byte is then registered into the result register. The
//   emitter sends one byte per cycle; single-byte items stream at one per
//   cycle. A two-entry job queue sits between classifier and emitter, and
//   busy is high while it is full.
// Reset: synchronous, clears the queue, the emitter and sets the timestamp
//   type to 255.

module msgpack_header_encoder_core import mhe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_operation,
   input  logic [63:0] req_value_bits,
   input  logic [31:0] req_length,
   input  logic [31:0] req_nanoseconds,
   input  logic [7:0]  req_ext_type,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_timestamp_ext_type
);

   queue_status_type q_status;
   job_type          front_job;
   job_type          head_job;
   logic             push;
   logic             pop;
   logic             accept;

   assign busy      = q_status.full;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // classifier
   mhe_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .accept                 (accept),
      .req_operation          (req_operation),
      .req_value_bits         (req_value_bits),
      .req_length             (req_length),
      .req_nanoseconds        (req_nanoseconds),
      .req_ext_type           (req_ext_type),
      .req_payload_byte       (req_payload_byte),
      .csr_write              (csr_valid && csr_ready),
      .csr_timestamp_ext_type (csr_timestamp_ext_type),
      .push                   (push),
      .job                    (front_job)
   );

   // job queue
   mhe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .pop      (pop),
      .head     (head_job),
      .status   (q_status)
   );

   // byte emitter
   mhe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head_job),
      .status       (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== sv/mhe_checker.sv =====
// mhe_checker: port-level checks of msgpack_header_encoder_core
// bound to the top level; no package dependency

module mhe_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_last
);

   // reset leaves no result pending and the input open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("result or busy after reset");

   // busy only rises after a transaction was taken
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ($past(start) && !$past(busy)))
      else $error("busy rose without an accepted transaction");

   // a result stream from idle starts only after an accepted transaction
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(start && !busy, 2))
      else $error("result without an accepted transaction");

   // bytes of one transaction come out without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a transaction's bytes");

endmodule

bind msgpack_header_encoder_core mhe_checker u_mhe_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);

// ===== tb/msgpack_header_encoder_core_test.sv =====
// msgpack_header_encoder_core_test: self-checking bench for the msgpack byte encoder
// predicts every encoded byte and last flag and checks the rsp_ stream against it
// depends on mhe_pkg and msgpack_header_encoder_core

module msgpack_header_encoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mhe_pkg::*;

   // codes that the encoder takes but turns into no bytes
   localparam logic [3:0] OP_UNUSED_FIRST = 4'd13;
   localparam logic [3:0] OP_UNUSED_MID   = 4'd14;
   localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

   // cycles to let pass once no bytes are expected any more
   localparam int SETTLE_CYCLES = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } enc_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_operation = '0;
   logic [63:0] req_value_bits = '0;
   logic [31:0] req_length = '0;
   logic [31:0] req_nanoseconds = '0;
   logic [7:0]  req_ext_type = '0;
   logic [7:0]  req_payload_byte = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_timestamp_ext_type = '0;

   // bytes still to come, oldest first
   enc_byte_type expected_bytes[$];
   // bytes of the item being encoded
   logic [7:0] item_bytes[$];
   // copy of the timestamp type register
   logic [7:0] ts_type_shadow = TS_EXT_TYPE_RESET;

   int mismatches = 0;
   int bytes_checked = 0;
   int items_sent = 0;
   int type_writes = 0;
   int op_count[16];
   int burst_left = 0;

   msgpack_header_encoder_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_operation          (req_operation),
      .req_value_bits         (req_value_bits),
      .req_length             (req_length),
      .req_nanoseconds        (req_nanoseconds),
      .req_ext_type           (req_ext_type),
      .req_payload_byte       (req_payload_byte),
      .rsp_valid              (rsp_valid),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_last               (rsp_last),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_timestamp_ext_type (csr_timestamp_ext_type)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop if the stream hangs
   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d at %0t ns: %s", mismatches, $realtime, what);
   endtask

   // ---------------------------------------------------------------
   // byte predictor
   // ---------------------------------------------------------------

   // big-endian bytes of the low nbytes of v
   function automatic void put_be(input logic [63:0] v, input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--)
         item_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_head(input logic [7:0] code, input logic [63:0] v,
                                    input int nbytes);
      item_bytes.push_back(code);
      put_be(v, nbytes);
   endfunction

   // 8, 16 or 32 bit length form
   function automatic void put_len3(input logic [31:0] len, input logic [7:0] c8,
                                    input logic [7:0] c16, input logic [7:0] c32);
      if (len < 32'h100) put_head(c8, {32'h0, len}, 1);
      else if (len < 32'h10000) put_head(c16, {32'h0, len}, 2);
      else put_head(c32, {32'h0, len}, 4);
   endfunction

   // fix form below 16, then 16 or 32 bit length
   function automatic void put_len_fix(input logic [31:0] len, input logic [7:0] fix,
                                       input logic [7:0] c16, input logic [7:0] c32);
      if (len < 32'd16) item_bytes.push_back(fix | {4'h0, len[3:0]});
      else if (len < 32'h10000) put_head(c16, {32'h0, len}, 2);
      else put_head(c32, {32'h0, len}, 4);
   endfunction

   function automatic void put_ext(input logic [31:0] len, input logic [7:0] ext_type);
      case (len)
         32'd1:   item_bytes.push_back(8'hd4);
         32'd2:   item_bytes.push_back(8'hd5);
         32'd4:   item_bytes.push_back(8'hd6);
         32'd8:   item_bytes.push_back(8'hd7);
         32'd16:  item_bytes.push_back(8'hd8);
         default: put_len3(len, 8'hc7, 8'hc8, 8'hc9);
      endcase
      item_bytes.push_back(ext_type);
   endfunction

   // shortest signed form
   function automatic void put_sint(input logic [63:0] v);
      if (!v[63]) begin
         if (v < 64'h80) item_bytes.push_back(v[7:0]);
         else if (v < 64'h100) put_head(8'hcc, v, 1);
         else if (v < 64'h10000) put_head(8'hcd, v, 2);
         else if (v < 64'h1_0000_0000) put_head(8'hce, v, 4);
         else put_head(8'hcf, v, 8);
      end else begin
         if (v >= 64'hffff_ffff_ffff_ffe0) item_bytes.push_back(v[7:0]);
         else if (v >= 64'hffff_ffff_ffff_ff80) put_head(8'hd0, v, 1);
         else if (v >= 64'hffff_ffff_ffff_8000) put_head(8'hd1, v, 2);
         else if (v >= 64'hffff_ffff_8000_0000) put_head(8'hd2, v, 4);
         else put_head(8'hd3, v, 8);
      end
   endfunction

   // expected bytes of one accepted transaction
   function automatic void encode_item(input logic [3:0] op, input logic [63:0] v,
                                       input logic [31:0] len, input logic [31:0] ns,
                                       input logic [7:0] et, input logic [7:0] pb);
      logic [63:0]  ts_word;
      enc_byte_type b;
      item_bytes.delete();
      case (op)
         OP_NIL:    item_bytes.push_back(8'hc0);
         OP_FALSE:  item_bytes.push_back(8'hc2);
         OP_TRUE:   item_bytes.push_back(8'hc3);
         OP_SINT:   put_sint(v);
         OP_UINT64: put_head(8'hcf, v, 8);
         OP_FLOAT:  put_head(8'hcb, v, 8);
         OP_BIN:    put_len3(len, 8'hc4, 8'hc5, 8'hc6);
         OP_STR: begin
            if (len < 32'd32) item_bytes.push_back(8'ha0 | {3'b000, len[4:0]});
            else put_len3(len, 8'hd9, 8'hda, 8'hdb);
         end
         OP_ARRAY:  put_len_fix(len, 8'h90, 8'hdc, 8'hdd);
         OP_MAP:    put_len_fix(len, 8'h80, 8'hde, 8'hdf);
         OP_EXT:    put_ext(len, et);
         OP_TSTAMP: begin
            // 32/64 bit forms when seconds fit 34 bits and ns fits 30 bits
            if (v[63:34] == '0 && ns[31:30] == 2'b00) begin
               ts_word = {ns[29:0], v[33:0]};
               if (ts_word[63:32] == '0) begin
                  put_ext(32'd4, ts_type_shadow);
                  put_be(ts_word, 4);
               end else begin
                  put_ext(32'd8, ts_type_shadow);
                  put_be(ts_word, 8);
               end
            end else begin
               put_ext(32'd12, ts_type_shadow);
               put_be({32'h0, ns}, 4);
               put_be(v, 8);
            end
         end
         OP_RAW:    item_bytes.push_back(pb);
         default: ;
      endcase
      foreach (item_bytes[i]) begin
         b.data = item_bytes[i];
         b.last = (i == item_bytes.size() - 1);
         expected_bytes.push_back(b);
      end
   endfunction

   // ---------------------------------------------------------------
   // output checker
   // ---------------------------------------------------------------

   // compare each strobed byte with the oldest expectation
   always @(posedge clock) begin : check_stream
      enc_byte_type want;
      if (!reset && rsp_valid) begin
         if (expected_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte 8'h%02h last %0b",
                                    rsp_out_byte, rsp_last));
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_out_byte !== want.data)
               flag_mismatch($sformatf("out_byte expected 8'h%02h got 8'h%02h",
                                       want.data, rsp_out_byte));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("last expected %0b got %0b (byte 8'h%02h)",
                                       want.last, rsp_last, want.data));
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // one input transaction, paced in bursts with random gaps
   task automatic send_item(input logic [3:0] op, input logic [63:0] v,
                            input logic [31:0] len, input logic [31:0] ns,
                            input logic [7:0] et, input logic [7:0] pb);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
      end
      burst_left--;
      start            <= 1'b1;
      req_operation    <= op;
      req_value_bits   <= v;
      req_length       <= len;
      req_nanoseconds  <= ns;
      req_ext_type     <= et;
      req_payload_byte <= pb;
      do @(posedge clock); while (busy);
      encode_item(op, v, len, ns, et, pb);
      op_count[op]++;
      items_sent++;
   endtask

   // stop sending and wait until every expected byte has come
   task automatic drain_encoder();
      start <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // write the timestamp type register while idle
   task automatic write_ts_type(input logic [7:0] value);
      csr_valid              <= 1'b1;
      csr_timestamp_ext_type <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ts_type_shadow = value;
      type_writes++;
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // full 96-bit timestamp with the type byte left at its reset value
   task automatic test_reset_ts_type();
      send_item(OP_TSTAMP, 64'hffff_ffff_ffff_ffff, '0, 32'hffff_ffff, 8'h00, 8'h00);
   endtask

   // fixed codes, integer extremes, float, raw and unused codes
   task automatic test_scalars();
      send_item(OP_NIL, {$urandom, $urandom}, $urandom, $urandom, 8'hff, 8'hff);
      send_item(OP_FALSE, '0, '0, '0, 8'h00, 8'h00);
      send_item(OP_TRUE, '1, '1, '1, 8'hff, 8'hff);
      send_item(OP_SINT, 64'hffff_ffff_ffff_ffff, '0, '0, 8'h00, 8'h00);
      send_item(OP_SINT, 64'h8000_0000_0000_0000, '0, '0, 8'h00, 8'h00);
      send_item(OP_SINT, 64'h7fff_ffff_ffff_ffff, '0, '0, 8'h00, 8'h00);
      send_item(OP_UINT64, 64'hffff_ffff_ffff_ffff, '0, '0, 8'h00, 8'h00);
      send_item(OP_FLOAT, 64'h4009_21fb_5444_2d18, '0, '0, 8'h00, 8'h00);
      send_item(OP_RAW, '0, '0, '0, 8'h00, 8'hff);
      send_item(OP_UNUSED_FIRST, '1, '1, '1, 8'hff, 8'hff);
      send_item(OP_UNUSED_LAST, '0, '0, '0, 8'h00, 8'h00);
   endtask

   // length headers at the form boundaries, ext of length zero
   task automatic test_headers();
      send_item(OP_BIN, '0, 32'd0, '0, 8'h00, 8'h00);
      send_item(OP_BIN, '0, 32'hffff_ffff, '0, 8'h00, 8'h00);
      send_item(OP_STR, '0, 32'd31, '0, 8'h00, 8'h00);
      send_item(OP_STR, '0, 32'd32, '0, 8'h00, 8'h00);
      send_item(OP_ARRAY, '0, 32'd15, '0, 8'h00, 8'h00);
      send_item(OP_ARRAY, '0, 32'd16, '0, 8'h00, 8'h00);
      send_item(OP_MAP, '0, 32'hffff, '0, 8'h00, 8'h00);
      send_item(OP_MAP, '0, 32'h1_0000, '0, 8'h00, 8'h00);
      send_item(OP_EXT, '0, 32'd0, '0, 8'hff, 8'h00);
      send_item(OP_EXT, '0, 32'd16, '0, 8'h00, 8'h00);
      send_item(OP_EXT, '0, 32'd3, '0, 8'h5a, 8'h00);
   endtask

   // 32, 64 and 96 bit timestamp forms, ns above 30 bits kept whole
   task automatic test_timestamps();
      send_item(OP_TSTAMP, 64'hffff_ffff, '0, 32'd0, 8'h00, 8'h00);
      send_item(OP_TSTAMP, 64'h3_ffff_ffff, '0, 32'h3fff_ffff, 8'h00, 8'h00);
      send_item(OP_TSTAMP, 64'd1, '0, 32'h4000_0000, 8'h00, 8'h00);
   endtask

   // random mix: headers followed by their payload bytes, scalars, noise
   task automatic test_random_stream(input int n_items);
      int          sent;
      int          k;
      logic [3:0]  op;
      logic [31:0] len;
      logic [63:0] v;
      logic [31:0] ns;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // well-formed header and payload transactions
               case ($urandom_range(0, 2))
                  0: op = OP_BIN;
                  1: op = OP_STR;
                  default: op = OP_EXT;
               endcase
               len = $urandom_range(0, 18);
               send_item(op, {$urandom, $urandom}, len, $urandom,
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               repeat (len)
                  send_item(OP_RAW, {$urandom, $urandom}, $urandom, $urandom,
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               sent += 1 + len;
            end
            4, 5: begin
               // headers with lengths near the form boundaries
               case ($urandom_range(0, 4))
                  0: op = OP_BIN;
                  1: op = OP_STR;
                  2: op = OP_ARRAY;
                  3: op = OP_MAP;
                  default: op = OP_EXT;
               endcase
               case ($urandom_range(0, 3))
                  0: len = $urandom_range(0, 40);
                  1: begin
                     case ($urandom_range(0, 3))
                        0: len = 32'd16;
                        1: len = 32'd32;
                        2: len = 32'h100;
                        default: len = 32'h1_0000;
                     endcase
                     len = len + $urandom_range(0, 2) - 1;
                  end
                  2: len = $urandom;
                  default: len = $urandom_range(0, 20);
               endcase
               send_item(op, {$urandom, $urandom}, len, $urandom,
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               sent++;
            end
            6, 7, 8: begin
               // scalars with values near the integer form boundaries
               k = $urandom_range(0, 6);
               op = (k == 6) ? OP_TSTAMP : 4'(k);
               case ($urandom_range(0, 4))
                  0: v = 64'($urandom_range(0, 300));
                  1: begin
                     k = $urandom_range(5, 63);
                     v = (64'd1 << k) - 64'd2 + $urandom_range(0, 3);
                  end
                  2: begin
                     k = $urandom_range(5, 63);
                     v = -((64'd1 << k) - 64'd2 + $urandom_range(0, 3));
                  end
                  3: v = {$urandom, $urandom};
                  default: v = 64'hffff_ffff_ffff_ffff - $urandom_range(0, 300);
               endcase
               ns = $urandom;
               if (op == OP_TSTAMP) begin
                  case ($urandom_range(0, 2))
                     0: v = {32'h0, $urandom};
                     1: v = {30'h0, 2'($urandom_range(0, 3)), $urandom};
                     default: ;
                  endcase
                  case ($urandom_range(0, 2))
                     0: ns = '0;
                     1: ns = $urandom & 32'h3fff_ffff;
                     default: ;
                  endcase
               end
               send_item(op, v, $urandom, ns, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
               sent++;
            end
            default: begin
               // noise over every code including the unused ones
               send_item(4'($urandom_range(0, 15)), {$urandom, $urandom}, $urandom,
                         $urandom, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
               sent++;
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_ts_type();
      drain_encoder();
      write_ts_type(8'h00);
      test_scalars();
      test_headers();
      test_timestamps();
      drain_encoder();

      write_ts_type(8'($urandom_range(0, 255)));
      test_random_stream(50);
      drain_encoder();
      write_ts_type(8'hff);
      test_random_stream(50);
      drain_encoder();
      write_ts_type(8'($urandom_range(0, 255)));
      test_random_stream(50);
      drain_encoder();

      $display("covered %0d transactions, %0d bytes checked: %0d timestamps, %0d raw,",
               items_sent, bytes_checked, op_count[OP_TSTAMP], op_count[OP_RAW]);
      $display("%0d unused codes, timestamp type written %0d times, %0d mismatches",
               op_count[OP_UNUSED_FIRST] + op_count[OP_UNUSED_MID]
               + op_count[OP_UNUSED_LAST], type_writes, mismatches);
      if (mismatches == 0 && expected_bytes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
